// File: hw/rtl/trl_pkg.sv
// ----------------------------------------------------------------------------
// trl_pkg: shared types and constants for turn-limited heading rotation
// Widths, register indexes, reset values and the structs passed between the
// front end, the queue and the back end.
// ----------------------------------------------------------------------------
package trl_pkg;

  localparam int POS_WIDTH_DEF  = 24;
  localparam int UNIT_FRAC_DEF  = 14;
  localparam int QUEUE_DEPTH    = 2;

  // Normalized difference components have their larger magnitude in [2^30, 2^31).
  localparam int NORM_W         = 31;
  // Integer square root of a sum of two squares of NORM_W-bit values.
  localparam int SQRT_W         = 32;
  localparam int SQRT_IN_W      = 2 * SQRT_W;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_MAX_TURN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_MAX_TURN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FACING_COS   = 2'd2;

  localparam logic signed [15:0] COS_MAX_TURN_RST = 16'sd0;
  localparam logic        [14:0] SIN_MAX_TURN_RST = 15'd16384;
  localparam logic signed [15:0] FACING_COS_RST   = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] cos_max_turn;
    logic        [14:0] sin_max_turn;
    logic signed [15:0] facing_cos;
  } trl_cfg_t;

  typedef struct packed {
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               neg_x;
    logic               neg_y;
    logic               zero;
  } trl_pay_t;

  typedef struct packed {
    trl_pay_t            pay;
    logic [NORM_W-1:0]   nx;
    logic [NORM_W-1:0]   ny;
  } trl_qent_t;

  typedef struct packed {
    logic signed [15:0] new_heading_x;
    logic signed [15:0] new_heading_y;
    logic signed [15:0] new_vel_x;
    logic signed [15:0] new_vel_y;
    logic signed [15:0] side_x;
    logic signed [15:0] side_y;
    logic               facing;
  } trl_res_t;

endpackage

// File: hw/rtl/trl_front.sv
// ----------------------------------------------------------------------------
// trl_front: difference vector and normalization
// Forms the target-minus-position vector, flags a zero vector, and scales the
// magnitudes by a common power of two through a pipelined shifter.
// ----------------------------------------------------------------------------
module trl_front #(
  parameter int POS_WIDTH = trl_pkg::POS_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic                        full_i,
  input  logic signed [POS_WIDTH-1:0] pos_x_i,
  input  logic signed [POS_WIDTH-1:0] pos_y_i,
  input  logic signed [POS_WIDTH-1:0] target_x_i,
  input  logic signed [POS_WIDTH-1:0] target_y_i,
  input  logic signed [15:0]          heading_x_i,
  input  logic signed [15:0]          heading_y_i,
  input  logic signed [15:0]          vel_x_i,
  input  logic signed [15:0]          vel_y_i,
  output logic                        valid_o,
  output trl_pkg::trl_qent_t          ent_o
);

  localparam int DW = POS_WIDTH + 1;
  localparam int EW = (POS_WIDTH > trl_pkg::NORM_W) ? POS_WIDTH : trl_pkg::NORM_W;
  localparam int NS = $clog2(EW);

  logic en;
  assign en = !full_i;

  logic signed [DW-1:0] dx, dy;
  logic        [DW-1:0] abs_x, abs_y;
  assign dx    = DW'(target_x_i) - DW'(pos_x_i);
  assign dy    = DW'(target_y_i) - DW'(pos_y_i);
  assign abs_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign abs_y = dy[DW-1] ? DW'(-dy) : DW'(dy);

  logic                  a_v_q;
  logic [POS_WIDTH-1:0]  a_ax_q, a_ay_q;
  trl_pkg::trl_pay_t     a_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ax_q        <= abs_x[POS_WIDTH-1:0];
      a_ay_q        <= abs_y[POS_WIDTH-1:0];
      a_pay_q.hx    <= heading_x_i;
      a_pay_q.hy    <= heading_y_i;
      a_pay_q.vx    <= vel_x_i;
      a_pay_q.vy    <= vel_y_i;
      a_pay_q.neg_x <= dx[DW-1];
      a_pay_q.neg_y <= dy[DW-1];
      a_pay_q.zero  <= (abs_x == '0) && (abs_y == '0);
    end
  end

  logic              n_v_q   [NS+1];
  logic [EW-1:0]     n_mx_q  [NS+1];
  logic [EW-1:0]     n_ax_q  [NS+1];
  logic [EW-1:0]     n_ay_q  [NS+1];
  trl_pkg::trl_pay_t n_pay_q [NS+1];

  // Stage zero: larger magnitude.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q[0] <= 1'b0;
    end else if (en) begin
      n_v_q[0] <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_mx_q[0]  <= EW'((a_ax_q > a_ay_q) ? a_ax_q : a_ay_q);
      n_ax_q[0]  <= EW'(a_ax_q);
      n_ay_q[0]  <= EW'(a_ay_q);
      n_pay_q[0] <= a_pay_q;
    end
  end

  // Left-normalize the larger magnitude, halving the shift step each stage.
  for (genvar k = 1; k <= NS; k++) begin : g_norm
    localparam int SH = 1 << (NS - k);
    logic do_shift;
    assign do_shift = (n_mx_q[k-1][EW-1 -: SH] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        n_v_q[k] <= 1'b0;
      end else if (en) begin
        n_v_q[k] <= n_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        n_mx_q[k]  <= do_shift ? (n_mx_q[k-1] << SH) : n_mx_q[k-1];
        n_ax_q[k]  <= do_shift ? (n_ax_q[k-1] << SH) : n_ax_q[k-1];
        n_ay_q[k]  <= do_shift ? (n_ay_q[k-1] << SH) : n_ay_q[k-1];
        n_pay_q[k] <= n_pay_q[k-1];
      end
    end
  end

  assign valid_o   = n_v_q[NS];
  assign ent_o.pay = n_pay_q[NS];
  assign ent_o.nx  = n_ax_q[NS][EW-1 -: trl_pkg::NORM_W];
  assign ent_o.ny  = n_ay_q[NS][EW-1 -: trl_pkg::NORM_W];

endmodule

// File: hw/rtl/trl_queue.sv
// ----------------------------------------------------------------------------
// trl_queue: short FIFO between front end and back end
// Register-based queue; the read entry is visible combinationally.
// ----------------------------------------------------------------------------
module trl_queue #(
  parameter int DEPTH = trl_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  trl_pkg::trl_qent_t data_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output trl_pkg::trl_qent_t data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  trl_pkg::trl_qent_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/trl_back.sv
// ----------------------------------------------------------------------------
// trl_back: square root, division and rotation pipeline
// Computes the unit target direction, dot and cross, picks the turn, and
// rotates heading and velocity. Never stalls.
// ----------------------------------------------------------------------------
module trl_back #(
  parameter int UNIT_FRAC_BITS = trl_pkg::UNIT_FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  trl_pkg::trl_qent_t ent_i,
  input  trl_pkg::trl_cfg_t  cfg_i,
  output logic               done_o,
  output trl_pkg::trl_res_t  res_o
);

  localparam int F   = UNIT_FRAC_BITS;
  localparam int TW  = F + 2;
  localparam int CW  = (TW > 16) ? TW : 16;
  localparam int PW  = CW + 17;
  localparam int NW  = F + trl_pkg::NORM_W + 1;
  localparam int DS  = F + 1;
  localparam int QW  = trl_pkg::SQRT_W;
  localparam int SQ  = trl_pkg::SQRT_W;
  localparam int SIW = trl_pkg::SQRT_IN_W;

  localparam logic        [PW-1:0] HALF    = PW'(1) << (F - 1);
  localparam logic signed [PW-1:0] ONE_P   = $signed(PW'(1) << F);
  localparam logic signed [PW-1:0] NONE_P  = -ONE_P;
  localparam logic signed [PW-1:0] VMAX_P  = $signed(PW'(32767));
  localparam logic signed [PW-1:0] VMIN_P  = ~VMAX_P;

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    mag = (mag + HALF) >> F;
    return v[PW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [PW-1:0] clamp_one(input logic signed [PW-1:0] v);
    return (v > ONE_P) ? ONE_P : ((v < NONE_P) ? NONE_P : v);
  endfunction

  function automatic logic signed [PW-1:0] sat_vel(input logic signed [PW-1:0] v);
    return (v > VMAX_P) ? VMAX_P : ((v < VMIN_P) ? VMIN_P : v);
  endfunction

  // Squares of the normalized components.
  logic                       p1_v_q;
  trl_pkg::trl_qent_t         p1_e_q;
  logic [2*trl_pkg::NORM_W-1:0] p1_sx_q, p1_sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else         p1_v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    p1_e_q  <= ent_i;
    p1_sx_q <= ent_i.nx * ent_i.nx;
    p1_sy_q <= ent_i.ny * ent_i.ny;
  end

  // Integer square root, one result bit per stage.
  logic               sq_v_q    [SQ+1];
  trl_pkg::trl_qent_t sq_e_q    [SQ+1];
  logic [SIW-1:0]     sq_n_q    [SQ+1];
  logic [QW+1:0]      sq_rem_q  [SQ+1];
  logic [QW-1:0]      sq_root_q [SQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q[0] <= 1'b0;
    else         sq_v_q[0] <= p1_v_q;
  end

  always_ff @(posedge clk_i) begin
    sq_e_q[0]    <= p1_e_q;
    sq_n_q[0]    <= SIW'(p1_sx_q) + SIW'(p1_sy_q);
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  for (genvar i = 1; i <= SQ; i++) begin : g_sqrt
    logic [QW+3:0] t, trial;
    logic          ge;
    assign t     = {sq_rem_q[i-1], sq_n_q[i-1][SIW-1 -: 2]};
    assign trial = {2'b00, sq_root_q[i-1], 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_v_q[i] <= 1'b0;
      else         sq_v_q[i] <= sq_v_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      sq_e_q[i]    <= sq_e_q[i-1];
      sq_n_q[i]    <= sq_n_q[i-1] << 2;
      sq_rem_q[i]  <= ge ? (QW+2)'(t - trial) : (QW+2)'(t);
      sq_root_q[i] <= {sq_root_q[i-1][QW-2:0], ge};
    end
  end

  // Rounded division of each component by the root, one quotient bit per stage.
  logic              dv_v_q   [DS+1];
  trl_pkg::trl_pay_t dv_pay_q [DS+1];
  logic [QW-1:0]     dv_q_q   [DS+1];
  logic [QW-1:0]     dv_rx_q  [DS+1];
  logic [QW-1:0]     dv_ry_q  [DS+1];
  logic [DS-1:0]     dv_lx_q  [DS+1];
  logic [DS-1:0]     dv_ly_q  [DS+1];
  logic [DS-1:0]     dv_ux_q  [DS+1];
  logic [DS-1:0]     dv_uy_q  [DS+1];

  logic [NW-1:0] num_x, num_y;
  assign num_x = (NW'(sq_e_q[SQ].nx) << F) + NW'(sq_root_q[SQ] >> 1);
  assign num_y = (NW'(sq_e_q[SQ].ny) << F) + NW'(sq_root_q[SQ] >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_v_q[0] <= 1'b0;
    else         dv_v_q[0] <= sq_v_q[SQ];
  end

  always_ff @(posedge clk_i) begin
    dv_pay_q[0] <= sq_e_q[SQ].pay;
    dv_q_q[0]   <= sq_root_q[SQ];
    dv_rx_q[0]  <= QW'(num_x >> DS);
    dv_ry_q[0]  <= QW'(num_y >> DS);
    dv_lx_q[0]  <= num_x[DS-1:0];
    dv_ly_q[0]  <= num_y[DS-1:0];
    dv_ux_q[0]  <= '0;
    dv_uy_q[0]  <= '0;
  end

  for (genvar j = 1; j <= DS; j++) begin : g_div
    logic [QW:0] tx_w, ty_w, qd;
    logic        gx, gy;
    assign qd   = {1'b0, dv_q_q[j-1]};
    assign tx_w = {dv_rx_q[j-1], dv_lx_q[j-1][DS-1]};
    assign ty_w = {dv_ry_q[j-1], dv_ly_q[j-1][DS-1]};
    assign gx   = (tx_w >= qd);
    assign gy   = (ty_w >= qd);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_v_q[j] <= 1'b0;
      else         dv_v_q[j] <= dv_v_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      dv_pay_q[j] <= dv_pay_q[j-1];
      dv_q_q[j]   <= dv_q_q[j-1];
      dv_rx_q[j]  <= gx ? QW'(tx_w - qd) : QW'(tx_w);
      dv_ry_q[j]  <= gy ? QW'(ty_w - qd) : QW'(ty_w);
      dv_lx_q[j]  <= dv_lx_q[j-1] << 1;
      dv_ly_q[j]  <= dv_ly_q[j-1] << 1;
      dv_ux_q[j]  <= {dv_ux_q[j-1][DS-2:0], gx};
      dv_uy_q[j]  <= {dv_uy_q[j-1][DS-2:0], gy};
    end
  end

  // Signed unit direction.
  logic signed [TW-1:0] ux_s, uy_s;
  assign ux_s = $signed({1'b0, dv_ux_q[DS]});
  assign uy_s = $signed({1'b0, dv_uy_q[DS]});

  logic                 t_v_q;
  trl_pkg::trl_pay_t    t_pay_q;
  logic signed [TW-1:0] t_tx_q, t_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t_v_q <= 1'b0;
    else         t_v_q <= dv_v_q[DS];
  end

  always_ff @(posedge clk_i) begin
    t_pay_q <= dv_pay_q[DS];
    t_tx_q  <= dv_pay_q[DS].neg_x ? -ux_s : ux_s;
    t_ty_q  <= dv_pay_q[DS].neg_y ? -uy_s : uy_s;
  end

  // Dot and cross products.
  logic                 pp_v_q;
  trl_pkg::trl_pay_t    pp_pay_q;
  logic signed [TW-1:0] pp_tx_q, pp_ty_q;
  logic signed [PW-1:0] pp_hxtx_q, pp_hyty_q, pp_hxty_q, pp_hytx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pp_v_q <= 1'b0;
    else         pp_v_q <= t_v_q;
  end

  always_ff @(posedge clk_i) begin
    pp_pay_q  <= t_pay_q;
    pp_tx_q   <= t_tx_q;
    pp_ty_q   <= t_ty_q;
    pp_hxtx_q <= t_pay_q.hx * t_tx_q;
    pp_hyty_q <= t_pay_q.hy * t_ty_q;
    pp_hxty_q <= t_pay_q.hx * t_ty_q;
    pp_hytx_q <= t_pay_q.hy * t_tx_q;
  end

  logic signed [PW-1:0] dot_w, cross_w;
  assign dot_w   = clamp_one(rnd(pp_hxtx_q + pp_hyty_q));
  assign cross_w = clamp_one(rnd(pp_hxty_q - pp_hytx_q));

  logic                 d_v_q;
  trl_pkg::trl_pay_t    d_pay_q;
  logic signed [TW-1:0] d_tx_q, d_ty_q, d_dot_q, d_cross_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else         d_v_q <= pp_v_q;
  end

  always_ff @(posedge clk_i) begin
    d_pay_q   <= pp_pay_q;
    d_tx_q    <= pp_tx_q;
    d_ty_q    <= pp_ty_q;
    d_dot_q   <= dot_w[TW-1:0];
    d_cross_q <= cross_w[TW-1:0];
  end

  // Decide between facing, a full turn onto the target, and a limited turn.
  logic signed [CW-1:0] dot_c, cross_c, cos_c, sin_c, fac_c;
  logic                 small_w, facing_w;
  assign dot_c    = CW'(d_dot_q);
  assign cross_c  = CW'(d_cross_q);
  assign cos_c    = CW'(cfg_i.cos_max_turn);
  assign fac_c    = CW'(cfg_i.facing_cos);
  assign sin_c    = CW'($signed({1'b0, cfg_i.sin_max_turn}));
  assign small_w  = (dot_c >= cos_c);
  assign facing_w = d_pay_q.zero || (dot_c >= fac_c);

  logic                 s_v_q, s_facing_q, s_small_q;
  trl_pkg::trl_pay_t    s_pay_q;
  logic signed [TW-1:0] s_tx_q, s_ty_q;
  logic signed [CW-1:0] s_c_q, s_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_v_q <= 1'b0;
    else         s_v_q <= d_v_q;
  end

  always_ff @(posedge clk_i) begin
    s_pay_q    <= d_pay_q;
    s_tx_q     <= d_tx_q;
    s_ty_q     <= d_ty_q;
    s_facing_q <= facing_w;
    s_small_q  <= small_w;
    s_c_q      <= small_w ? dot_c : cos_c;
    s_s_q      <= small_w ? cross_c : (cross_c[CW-1] ? -sin_c : sin_c);
  end

  // Rotation products.
  logic                 m_v_q, m_facing_q, m_small_q;
  trl_pkg::trl_pay_t    m_pay_q;
  logic signed [TW-1:0] m_tx_q, m_ty_q;
  logic signed [PW-1:0] m_hxc_q, m_hys_q, m_hxs_q, m_hyc_q;
  logic signed [PW-1:0] m_vxc_q, m_vys_q, m_vxs_q, m_vyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else         m_v_q <= s_v_q;
  end

  always_ff @(posedge clk_i) begin
    m_pay_q    <= s_pay_q;
    m_tx_q     <= s_tx_q;
    m_ty_q     <= s_ty_q;
    m_facing_q <= s_facing_q;
    m_small_q  <= s_small_q;
    m_hxc_q    <= s_pay_q.hx * s_c_q;
    m_hys_q    <= s_pay_q.hy * s_s_q;
    m_hxs_q    <= s_pay_q.hx * s_s_q;
    m_hyc_q    <= s_pay_q.hy * s_c_q;
    m_vxc_q    <= s_pay_q.vx * s_c_q;
    m_vys_q    <= s_pay_q.vy * s_s_q;
    m_vxs_q    <= s_pay_q.vx * s_s_q;
    m_vyc_q    <= s_pay_q.vy * s_c_q;
  end

  logic signed [PW-1:0] nhx_w, nhy_w, nvx_w, nvy_w, side_x_w;
  always_comb begin
    if (m_facing_q) begin
      nhx_w = PW'(m_pay_q.hx);
      nhy_w = PW'(m_pay_q.hy);
      nvx_w = PW'(m_pay_q.vx);
      nvy_w = PW'(m_pay_q.vy);
    end else begin
      if (m_small_q) begin
        nhx_w = PW'(m_tx_q);
        nhy_w = PW'(m_ty_q);
      end else begin
        nhx_w = rnd(m_hxc_q - m_hys_q);
        nhy_w = rnd(m_hxs_q + m_hyc_q);
      end
      nvx_w = sat_vel(rnd(m_vxc_q - m_vys_q));
      nvy_w = sat_vel(rnd(m_vxs_q + m_vyc_q));
    end
    nhx_w    = clamp_one(nhx_w);
    nhy_w    = clamp_one(nhy_w);
    side_x_w = -nhy_w;
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= m_v_q;
  end

  always_ff @(posedge clk_i) begin
    res_o.new_heading_x <= nhx_w[15:0];
    res_o.new_heading_y <= nhy_w[15:0];
    res_o.new_vel_x     <= nvx_w[15:0];
    res_o.new_vel_y     <= nvy_w[15:0];
    res_o.side_x        <= side_x_w[15:0];
    res_o.side_y        <= nhx_w[15:0];
    res_o.facing        <= m_facing_q;
  end

  assign done_o = done_q;

endmodule

// File: hw/rtl/turn_limited_heading_rotation.sv
// ----------------------------------------------------------------------------
// turn_limited_heading_rotation: turn a heading toward a target point
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// A new beat is taken at every clock edge where start is high and busy is low,
// so one entity update can enter each cycle. Each result is presented on the
// result ports for exactly one cycle with done_o high and must be captured
// then, since the receiver cannot stall the block. Most of the pipeline is the
// 32-stage square root of the squared distance and the division stages (one per
// quotient bit) that form the unit target direction.
// Results leave in acceptance order.
// The configuration registers should only be written while no beat is in
// flight; they are read directly by the back end.
module turn_limited_heading_rotation #(
  parameter int POS_WIDTH      = trl_pkg::POS_WIDTH_DEF,
  parameter int UNIT_FRAC_BITS = trl_pkg::UNIT_FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [trl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [trl_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic signed [POS_WIDTH-1:0]       pos_x_i,
  input  logic signed [POS_WIDTH-1:0]       pos_y_i,
  input  logic signed [POS_WIDTH-1:0]       target_x_i,
  input  logic signed [POS_WIDTH-1:0]       target_y_i,
  input  logic signed [15:0]                heading_x_i,
  input  logic signed [15:0]                heading_y_i,
  input  logic signed [15:0]                vel_x_i,
  input  logic signed [15:0]                vel_y_i,
  output logic                              done_o,
  output logic signed [15:0]                new_heading_x_o,
  output logic signed [15:0]                new_heading_y_o,
  output logic signed [15:0]                new_vel_x_o,
  output logic signed [15:0]                new_vel_y_o,
  output logic signed [15:0]                side_x_o,
  output logic signed [15:0]                side_y_o,
  output logic                              facing_o
);

  // Configuration registers. Writes to an unused index are dropped.
  trl_pkg::trl_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_max_turn <= trl_pkg::COS_MAX_TURN_RST;
      cfg_q.sin_max_turn <= trl_pkg::SIN_MAX_TURN_RST;
      cfg_q.facing_cos   <= trl_pkg::FACING_COS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        trl_pkg::CFG_COS_MAX_TURN: cfg_q.cos_max_turn <= $signed(cfg_data_i);
        trl_pkg::CFG_SIN_MAX_TURN: cfg_q.sin_max_turn <= cfg_data_i[14:0];
        trl_pkg::CFG_FACING_COS:   cfg_q.facing_cos   <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The front end stalls only when the queue is full; busy tells the sender.
  logic               q_full, q_valid, f_valid, push, acc;
  trl_pkg::trl_qent_t f_ent, q_ent;

  assign busy = q_full;
  assign acc  = start && !busy;
  assign push = f_valid && !q_full;

  trl_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .full_i      (q_full),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .heading_x_i (heading_x_i),
    .heading_y_i (heading_y_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .valid_o     (f_valid),
    .ent_o       (f_ent)
  );

  // The back end never stalls, so it drains an entry every cycle one is there.
  trl_queue #(
    .DEPTH (trl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_ent),
    .pop_i   (q_valid),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_ent)
  );

  trl_pkg::trl_res_t res;

  trl_back #(
    .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ent_i   (q_ent),
    .cfg_i   (cfg_q),
    .done_o  (done_o),
    .res_o   (res)
  );

  assign new_heading_x_o = res.new_heading_x;
  assign new_heading_y_o = res.new_heading_y;
  assign new_vel_x_o     = res.new_vel_x;
  assign new_vel_y_o     = res.new_vel_y;
  assign side_x_o        = res.side_x;
  assign side_y_o        = res.side_y;
  assign facing_o        = res.facing;

endmodule
